// ----- hw/rtl/osd_pkg.sv -----
`timescale 1ns / 1ps

package osd_pkg;

    localparam int TGT_W   = 31;
    localparam int XTAL_W  = 28;
    localparam int HS_W    = 4;
    localparam int N1_W    = 8;
    localparam int DCO_W   = 33;
    localparam int RFREQ_W = 38;
    localparam int MULT_W  = 12;
    localparam int PROD_W  = TGT_W + MULT_W;
    localparam int K_W     = 7;
    localparam int J_W     = 3;

    localparam logic [K_W-1:0] N1_LAST  = K_W'(64);
    localparam logic [J_W-1:0] HS_LAST  = J_W'(5);

    localparam logic [DCO_W-1:0] DCO_MAX_HZ = 33'd5670000000;
    localparam logic [DCO_W-1:0] DCO_MIN_HZ = 33'd4850000000;

    localparam logic [XTAL_W-1:0] XTAL_RESET_HZ = 28'd114285000;

    // shift of the dco before the division, plus the dco bits themselves
    localparam int RFREQ_SHIFT = 28;
    localparam int DIV_STEPS   = DCO_W + RFREQ_SHIFT;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    typedef struct packed {
        logic              hit;
        logic [HS_W-1:0]   hs;
        logic [N1_W-1:0]   n1;
        logic [DCO_W-1:0]  dco;
    } t_srch_res;

    // high-speed divider in trial order
    function automatic logic [HS_W-1:0] hs_of(input logic [J_W-1:0] j);
        logic [HS_W-1:0] v;
        case (j)
            3'd0:    v = 4'd11;
            3'd1:    v = 4'd9;
            3'd2:    v = 4'd7;
            3'd3:    v = 4'd6;
            3'd4:    v = 4'd5;
            default: v = 4'd4;
        endcase
        return v;
    endfunction

    // output divider: 1 for the first step, then twice the step index
    function automatic logic [N1_W-1:0] n1_of(input logic [K_W-1:0] k);
        logic [N1_W-1:0] v;
        v = (k == '0) ? N1_W'(1) : {k, 1'b0};
        return v;
    endfunction

endpackage

// ----- hw/rtl/osd_search.sv -----
`timescale 1ns / 1ps

module osd_search (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [osd_pkg::TGT_W-1:0] i_target,
    output logic                      o_done,
    output osd_pkg::t_srch_res        o_res
);
    import osd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_CMP  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [TGT_W-1:0]   r_tgt, n_tgt;
    logic [K_W-1:0]     r_k, n_k;
    logic [J_W-1:0]     r_j, n_j;
    logic [MULT_W-1:0]  r_mult, n_mult;
    logic [PROD_W-1:0]  r_prod;
    logic               r_done, n_done;
    t_srch_res          r_res, n_res;

    logic               w_over;
    logic               w_in;

    assign w_over = r_prod > PROD_W'(DCO_MAX_HZ);
    assign w_in   = r_prod > PROD_W'(DCO_MIN_HZ);

    always_comb begin
        n_state = r_state;
        n_tgt   = r_tgt;
        n_k     = r_k;
        n_j     = r_j;
        n_done  = 1'b0;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_tgt   = i_target;
                    n_k     = '0;
                    n_j     = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!w_over && w_in) begin
                    n_res   = '{hit: 1'b1, hs: hs_of(r_j), n1: n1_of(r_k),
                                dco: r_prod[DCO_W-1:0]};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (w_over || r_j == HS_LAST) begin
                    // too fast or out of dividers: next output divider, or a miss after the last one
                    if (r_k == N1_LAST) begin
                        n_res   = '0;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + K_W'(1);
                        n_j     = '0;
                        n_state = S_MUL;
                    end
                end else begin
                    n_j     = r_j + J_W'(1);
                    n_state = S_MUL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // combined divider of the next trial, registered ahead of the wide product
    assign n_mult = MULT_W'(n1_of(n_k)) * MULT_W'(hs_of(n_j));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt  <= n_tgt;
        r_k    <= n_k;
        r_j    <= n_j;
        r_mult <= n_mult;
        if (r_state == S_MUL) begin
            r_prod <= r_tgt * r_mult;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- hw/rtl/osd_divider.sv -----
`timescale 1ns / 1ps

module osd_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [osd_pkg::DCO_W-1:0]   i_dco,
    input  logic [osd_pkg::XTAL_W-1:0]  i_xtal,
    output logic                        o_done,
    output logic [osd_pkg::RFREQ_W-1:0] o_quo
);
    import osd_pkg::*;

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_RUN  = 2'b10
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [XTAL_W-1:0]   r_rem;
    logic [DCO_W-1:0]    r_dvd;
    logic [RFREQ_W-1:0]  r_quo;
    logic                r_ovf;
    logic                r_done;

    logic [XTAL_W:0]     w_trial;
    logic [XTAL_W:0]     w_diff;
    logic                w_ge;

    // one restoring step per cycle; a zero divisor yields all ones
    assign w_trial = {r_rem, r_dvd[DCO_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_xtal};
    assign w_diff  = w_trial - {1'b0, i_xtal};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= D_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_dvd <= i_dco;
            if (i_start) begin
                r_quo <= '0;
                r_ovf <= 1'b0;
            end
        end else begin
            r_cnt <= r_cnt + CNT_W'(1);
            r_rem <= w_ge ? w_diff[XTAL_W-1:0] : w_trial[XTAL_W-1:0];
            r_dvd <= {r_dvd[DCO_W-2:0], 1'b0};
            r_quo <= {r_quo[RFREQ_W-2:0], w_ge};
            // quotient bits above the word only mark saturation
            r_ovf <= r_ovf | r_quo[RFREQ_W-1];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_ovf ? '1 : r_quo;

endmodule

// ----- hw/rtl/oscillator_divider_search.sv -----
`timescale 1ns / 1ps

// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+---------------------------------------
// s (input) | in        | i_s_tvalid / o_s_tready  | i_s_tdata[30:0] target_freq_hz
// m (result)| out       | o_m_tvalid / i_m_tready  | o_m_tuser found, o_m_tdata see port
// cfg       | in        | i_cfg_wr_en              | i_cfg_wr_data xtal_freq_hz
//
// one item at a time: the search tries divider pairs in turn, up to 65 x 6
// pairs, then the rfreq division produces one quotient bit per cycle, and
// the result is handed off to the result register
// a target with no valid pair skips the division
// the next item is taken once the current one has moved to the result register,
// even while that result still waits on i_m_tready
// reset is synchronous, active low, and restores the crystal register

module oscillator_divider_search (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // target_freq_hz[30:0], zero pad
    input  logic [31:0]  i_s_tdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // hs_divider[3:0], out_divider[11:4], dco_freq_hz[44:12], rfreq_word[82:45],
    // reg_byte0[90:83], reg_byte1[98:91], reg_byte2[106:99], reg_byte3[114:107],
    // reg_byte4[122:115], reg_byte5[130:123], zero pad
    output logic [135:0] o_m_tdata,
    // found
    output logic         o_m_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    input  logic         i_cfg_wr_en,
    input  logic [27:0]  i_cfg_wr_data
);
    import osd_pkg::*;

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_SRCH = 4'b0010,
        T_DIV  = 4'b0100,
        T_OUT  = 4'b1000
    } t_state;

    t_state              r_state;
    logic [XTAL_W-1:0]   r_xtal;
    logic [135:0]        r_m_data;
    logic                r_m_user;
    logic                r_m_valid;

    logic                w_s_acc;
    logic                w_srch_done;
    t_srch_res           w_srch;
    logic                w_div_start;
    logic                w_div_done;
    logic [RFREQ_W-1:0]  w_quo;
    logic                w_load;

    logic [RFREQ_W-1:0]  w_rfreq;
    logic [6:0]          w_nm;
    logic [2:0]          w_hm;
    logic [7:0]          w_b0;
    logic [7:0]          w_b1;
    logic [135:0]        w_pack;

    assign o_s_tready  = (r_state == T_IDLE);
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_div_start = (r_state == T_SRCH) && w_srch_done && w_srch.hit;
    // result register frees up or drains in the same cycle
    assign w_load      = (r_state == T_OUT) && (!r_m_valid || i_m_tready);

    osd_search u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_s_acc),
        .i_target (i_s_tdata[TGT_W-1:0]),
        .o_done   (w_srch_done),
        .o_res    (w_srch)
    );

    osd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_dco   (w_srch.dco),
        .i_xtal  (r_xtal),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // sequencer over search, division and result hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            unique case (r_state)
                T_IDLE: begin
                    if (w_s_acc) begin
                        r_state <= T_SRCH;
                    end
                end
                T_SRCH: begin
                    if (w_srch_done) begin
                        r_state <= w_srch.hit ? T_DIV : T_OUT;
                    end
                end
                T_DIV: begin
                    if (w_div_done) begin
                        r_state <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (w_load) begin
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    // crystal frequency register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xtal <= XTAL_RESET_HZ;
        end else if (i_cfg_wr_en) begin
            r_xtal <= i_cfg_wr_data;
        end
    end

    // register byte packing; a failed search reports all zeros
    assign w_rfreq = w_srch.hit ? w_quo : '0;
    assign w_nm    = 7'(w_srch.n1 - N1_W'(1));
    assign w_hm    = 3'(w_srch.hs - HS_W'(4));
    assign w_b0    = {w_hm, w_nm[6:2]};
    assign w_b1    = {w_nm[1:0], w_rfreq[37:32]};

    always_comb begin
        w_pack = '0;
        if (w_srch.hit) begin
            w_pack[130:0] = {w_rfreq[7:0], w_rfreq[15:8], w_rfreq[23:16],
                             w_rfreq[31:24], w_b1, w_b0, w_rfreq,
                             w_srch.dco, w_srch.n1, w_srch.hs};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data <= w_pack;
            r_m_user <= w_srch.hit;
        end
    end

    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tvalid = r_m_valid;

endmodule

// ----- hw/rtl/osd_checker.sv -----
`timescale 1ns / 1ps

module osd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [135:0] o_m_tdata,
    input logic         o_m_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready
);
    import osd_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed under stall");

    // one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while busy");

    // failed search clears every field
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("nonzero fields on a failed search");

    // found pair uses a legal high-speed divider
    a_hs_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            (o_m_tdata[3:0] == 4'd4 || o_m_tdata[3:0] == 4'd5 ||
             o_m_tdata[3:0] == 4'd6 || o_m_tdata[3:0] == 4'd7 ||
             o_m_tdata[3:0] == 4'd9 || o_m_tdata[3:0] == 4'd11))
        else $error("illegal high-speed divider");

    // found dco lies in the band
    a_dco_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            o_m_tdata[44:12] > DCO_MIN_HZ && o_m_tdata[44:12] <= DCO_MAX_HZ)
        else $error("dco outside band");

endmodule

bind oscillator_divider_search osd_checker u_osd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

// ----- test/oscillator_divider_search_test.sv -----
`timescale 1ns / 1ps

module oscillator_divider_search_test;

    import osd_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 248;
    localparam int NUM_DIRECTED    = 21;
    localparam int LONG_HOLD       = 5000;
    localparam int HOLD_AFTER      = 150;

    // high-speed divider trial order, first trial in the low nibble
    localparam logic [23:0] HS_TRY = {4'd4, 4'd5, 4'd6, 4'd7, 4'd9, 4'd11};
    localparam logic [63:0] RFREQ_ALL_ONES = (64'd1 << RFREQ_W) - 64'd1;

    typedef struct packed {
        logic               found;
        logic [HS_W-1:0]    hs_divider;
        logic [N1_W-1:0]    out_divider;
        logic [DCO_W-1:0]   dco_freq_hz;
        logic [RFREQ_W-1:0] rfreq_word;
        logic [7:0]         reg_byte0;
        logic [7:0]         reg_byte1;
        logic [7:0]         reg_byte2;
        logic [7:0]         reg_byte3;
        logic [7:0]         reg_byte4;
        logic [7:0]         reg_byte5;
    } t_divider_choice;

    // none_found rows expect an all-zero result, the others go through the predictor
    typedef struct packed {
        logic             none_found;
        logic [TGT_W-1:0] target;
    } t_target_row;

    logic           i_clk;
    logic           i_rst_n       = 1'b0;
    logic [31:0]    i_s_tdata     = '0;
    logic           i_s_tvalid    = 1'b0;
    logic           o_s_tready;
    logic [135:0]   o_m_tdata;
    logic           o_m_tuser;
    logic           o_m_tvalid;
    logic           i_m_tready    = 1'b0;
    logic           i_cfg_wr_en   = 1'b0;
    logic [27:0]    i_cfg_wr_data = '0;

    t_divider_choice expected_choices[$];
    t_divider_choice oldest_choice;
    t_divider_choice seen_choice;
    logic [XTAL_W-1:0] xtal_hz;
    int mismatch_count = 0;
    int result_count   = 0;
    bit long_hold_done = 1'b0;

    t_target_row directed_rows [NUM_DIRECTED] = '{
        '{1'b1, 31'd0},              // zero target never finds a pair
        '{1'b1, 31'd1},              // far below any band
        '{1'b1, 31'h7FFF_FFFF},      // all ones, every n1 overshoots
        '{1'b1, 31'd1_500_000_000},  // far above the usable range, overshoots
        '{1'b0, 31'd500_000_000},    // plain hit at n1 1, hs 11
        '{1'b0, 31'd515_454_545},    // top edge of the band at n1 1
        '{1'b1, 31'd515_454_546},    // one above: overshoot on every n1
        '{1'b0, 31'd440_909_091},    // bottom edge of the band at n1 1
        '{1'b1, 31'd440_909_090},    // one below: under at n1 1, over at n1 2
        '{1'b0, 31'd3_444_603},      // lowest hit, n1 128
        '{1'b1, 31'd3_444_602},      // one below the lowest hit
        '{1'b0, 31'd257_727_272},    // top edge at n1 2
        '{1'b0, 31'd220_454_546},    // bottom edge at n1 2
        '{1'b1, 31'd100_000_000},    // falls in the gap between n1 4 and n1 6
        '{1'b0, 31'd10_000_000},
        '{1'b0, 31'd125_000_000},
        '{1'b1, 31'h4000_0000},
        '{1'b1, 31'h2AAA_AAAA},
        '{1'b1, 31'h5555_5555},
        '{1'b0, 31'd4_026_988},
        '{1'b0, 31'd40_000_000}
    };

    oscillator_divider_search u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tdata     (i_s_tdata),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // walk n1 then hs like the hardware, first dco inside the band wins
    function automatic t_divider_choice predict_dividers(input logic [TGT_W-1:0] tgt,
                                                         input logic [XTAL_W-1:0] xtal);
        t_divider_choice r;
        logic [63:0] n, d, q, f;
        logic [6:0]  n1_m1;
        logic [2:0]  hs_m4;
        bit          hit;
        bit          stop;
        r   = '0;
        hit = 1'b0;
        f   = 64'(tgt);
        for (int k = 0; k <= 64; k++) begin
            n    = (k == 0) ? 64'd1 : 64'(2 * k);
            stop = hit;
            for (int j = 0; j < 6; j++) begin
                if (!stop) begin
                    d = f * n * 64'(HS_TRY[j*4 +: 4]);
                    if (d > 64'(DCO_MAX_HZ)) begin
                        stop = 1'b1;   // hardware skips the rest of this n1 on overshoot
                    end else if (d > 64'(DCO_MIN_HZ)) begin
                        stop          = 1'b1;
                        hit           = 1'b1;
                        r.found       = 1'b1;
                        r.hs_divider  = HS_TRY[j*4 +: 4];
                        r.out_divider = N1_W'(n);
                        r.dco_freq_hz = DCO_W'(d);
                    end
                end
            end
        end
        if (!hit)
            return r;
        // zero crystal or an oversized quotient pins rfreq at all ones
        if (xtal == '0) begin
            q = RFREQ_ALL_ONES;
        end else begin
            q = (64'(r.dco_freq_hz) << RFREQ_SHIFT) / 64'(xtal);
            if (q > RFREQ_ALL_ONES)
                q = RFREQ_ALL_ONES;
        end
        r.rfreq_word = RFREQ_W'(q);
        n1_m1        = 7'(r.out_divider - 8'd1);
        hs_m4        = 3'(r.hs_divider - 4'd4);
        r.reg_byte0  = {hs_m4, n1_m1[6:2]};
        r.reg_byte1  = {n1_m1[1:0], r.rfreq_word[37:32]};
        r.reg_byte2  = r.rfreq_word[31:24];
        r.reg_byte3  = r.rfreq_word[23:16];
        r.reg_byte4  = r.rfreq_word[15:8];
        r.reg_byte5  = r.rfreq_word[7:0];
        return r;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // crystal settings per phase: extremes of the field and of the usable range
    function automatic logic [XTAL_W-1:0] xtal_for_phase(input int p);
        case (p)
            0:       return 28'd50_000_000;
            1:       return 28'd200_000_000;
            2:       return 28'hFFF_FFFF;
            3:       return 28'd0;
            4:       return 28'd1;
            5:       return 28'd5_000_000;   // rfreq saturates for a dco of 5.12 GHz and up
            6:       return XTAL_RESET_HZ;
            default: return XTAL_W'($urandom_range(50_000_000, 200_000_000));
        endcase
    endfunction

    // mix of raw field values, very low targets, in-band targets and band edges
    function automatic logic [TGT_W-1:0] random_target();
        int unsigned r;
        int unsigned k;
        logic [63:0] n, lo, hi;
        r = $urandom_range(0, 99);
        if (r < 30)
            return TGT_W'($urandom);
        if (r < 40)
            return TGT_W'($urandom_range(0, 3_500_000));
        k  = $urandom_range(0, 64);
        n  = (k == 0) ? 64'd1 : 64'(2 * k);
        lo = 64'(DCO_MIN_HZ) / (64'd11 * n);
        hi = 64'(DCO_MAX_HZ) / (64'd11 * n);
        if (r < 85)
            return TGT_W'(lo + 64'd1 + 64'($urandom_range(0, 32'(hi - lo - 64'd1))));
        // right at a band edge
        case ($urandom_range(0, 5))
            0:       return TGT_W'(lo - 64'd1);
            1:       return TGT_W'(lo);
            2:       return TGT_W'(lo + 64'd1);
            3:       return TGT_W'(hi - 64'd1);
            4:       return TGT_W'(hi);
            default: return TGT_W'(hi + 64'd1);
        endcase
    endfunction

    // offer one target after a gap, queue its expected choice once taken
    task automatic send_target(input logic [TGT_W-1:0] tgt, input t_divider_choice want,
                               input int gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, tgt};
        do @(posedge i_clk); while (!o_s_tready);
        expected_choices.push_back(want);
    endtask

    task automatic drain_choices();
        i_s_tvalid <= 1'b0;
        while (expected_choices.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_xtal(input logic [XTAL_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        xtal_hz        = v;
    endtask

    function automatic void compare_field(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // main stimulus: directed table, then random phases under several crystals
    initial begin : stimulus
        logic [TGT_W-1:0] tgt;
        xtal_hz = XTAL_RESET_HZ;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows run with the crystal at its reset value
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (directed_rows[i].none_found)
                send_target(directed_rows[i].target, '0, idle_len());
            else
                send_target(directed_rows[i].target,
                            predict_dividers(directed_rows[i].target, xtal_hz), idle_len());
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_choices();
            write_xtal(xtal_for_phase(p));
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                tgt = random_target();
                send_target(tgt, predict_dividers(tgt, xtal_hz), idle_len());
            end
        end

        drain_choices();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // result side ready: runs of ready, random stalls, one long hold-off
    // so the result register fills and the input side backs up
    initial begin : result_ready
        int unsigned run;
        int unsigned hold;
        forever begin
            i_m_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
            repeat (run) @(posedge i_clk);
            if (!long_hold_done && result_count >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                hold           = LONG_HOLD;
            end else begin
                hold = idle_len();
            end
            if (hold != 0) begin
                i_m_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    // every taken result is checked against the oldest queued choice
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            result_count++;
            seen_choice.found       = o_m_tuser;
            seen_choice.hs_divider  = o_m_tdata[3:0];
            seen_choice.out_divider = o_m_tdata[11:4];
            seen_choice.dco_freq_hz = o_m_tdata[44:12];
            seen_choice.rfreq_word  = o_m_tdata[82:45];
            seen_choice.reg_byte0   = o_m_tdata[90:83];
            seen_choice.reg_byte1   = o_m_tdata[98:91];
            seen_choice.reg_byte2   = o_m_tdata[106:99];
            seen_choice.reg_byte3   = o_m_tdata[114:107];
            seen_choice.reg_byte4   = o_m_tdata[122:115];
            seen_choice.reg_byte5   = o_m_tdata[130:123];
            if (expected_choices.size() == 0) begin
                $display("%0t ns: unexpected item, expected none got 0x%0h", $time,
                         seen_choice);
                mismatch_count++;
            end else begin
                oldest_choice = expected_choices.pop_front();
                compare_field("found", 64'(oldest_choice.found),
                              64'(seen_choice.found));
                compare_field("hs_divider", 64'(oldest_choice.hs_divider),
                              64'(seen_choice.hs_divider));
                compare_field("out_divider", 64'(oldest_choice.out_divider),
                              64'(seen_choice.out_divider));
                compare_field("dco_freq_hz", 64'(oldest_choice.dco_freq_hz),
                              64'(seen_choice.dco_freq_hz));
                compare_field("rfreq_word", 64'(oldest_choice.rfreq_word),
                              64'(seen_choice.rfreq_word));
                compare_field("reg_byte0", 64'(oldest_choice.reg_byte0),
                              64'(seen_choice.reg_byte0));
                compare_field("reg_byte1", 64'(oldest_choice.reg_byte1),
                              64'(seen_choice.reg_byte1));
                compare_field("reg_byte2", 64'(oldest_choice.reg_byte2),
                              64'(seen_choice.reg_byte2));
                compare_field("reg_byte3", 64'(oldest_choice.reg_byte3),
                              64'(seen_choice.reg_byte3));
                compare_field("reg_byte4", 64'(oldest_choice.reg_byte4),
                              64'(seen_choice.reg_byte4));
                compare_field("reg_byte5", 64'(oldest_choice.reg_byte5),
                              64'(seen_choice.reg_byte5));
            end
        end
    end

    // watchdog, several times the slowest legal run
    initial begin : watchdog
        #(100_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
